@@ src/sjis_pkg.sv @@
// Shared types, byte constants and byte-class functions for the Shift_JIS
// to ISO-2022-JP encoder. No dependencies; all files but sjis_if and sjis_chk import it.
`timescale 1ns / 1ps
`default_nettype none

package sjis_pkg;

  typedef logic [7:0] byte_t;

  // Most output bytes one input item can cause: a three-byte escape and a kanji pair.
  localparam int unsigned RUN_MAX = 5;
  localparam int unsigned CNT_W   = $clog2(RUN_MAX + 1);
  localparam int unsigned IDX_W   = $clog2(RUN_MAX);

  // Character set codes; the unused fourth code behaves as ASCII.
  typedef logic [1:0] cset_t;
  localparam cset_t CS_ASCII = 2'd0;
  localparam cset_t CS_KANA  = 2'd1;
  localparam cset_t CS_KANJI = 2'd2;

  // Escape sequence bytes.
  localparam byte_t ESC_CODE   = 8'h1B;
  localparam byte_t ESC_PAREN  = 8'h28;
  localparam byte_t ESC_DOLLAR = 8'h24;
  localparam byte_t FINAL_B    = 8'h42;
  localparam byte_t FINAL_I    = 8'h49;

  // Row and cell arithmetic constants.
  localparam byte_t ROW_HIGH_ADJ = 8'h40;
  localparam byte_t ROW_BASE     = 8'h70;
  localparam byte_t CELL_HI_BASE = 8'h7D;
  localparam byte_t CELL_LO_BASE = 8'h1F;
  localparam byte_t CELL_SPLIT   = 8'h9E;

  // One run of output bytes with its length, handed from decode to the output stage.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]        cnt;
  } run_t;

  function automatic logic is_ascii(input byte_t b);
    return b <= 8'h7F;
  endfunction

  function automatic logic is_kana(input byte_t b);
    return (b >= 8'hA1) && (b <= 8'hDF);
  endfunction

  function automatic logic is_lead(input byte_t b);
    return ((b >= 8'h81) && (b <= 8'h9F)) || ((b >= 8'hE0) && (b <= 8'hFC));
  endfunction

  function automatic logic is_trail(input byte_t b);
    return ((b >= 8'h40) && (b <= 8'h7E)) || ((b >= 8'h80) && (b <= 8'hFC));
  endfunction

  // Turns a lead and trail pair into JIS row (upper byte) and cell (lower byte).
  // All arithmetic wraps at eight bits.
  function automatic logic [15:0] kanji_row_cell(input byte_t lead, input byte_t trail);
    byte_t row;
    byte_t cell_b;
    byte_t base;
    row    = lead;
    cell_b = trail;
    if (row >= 8'hE0) begin
      row = row - ROW_HIGH_ADJ;
    end
    if (cell_b >= 8'h80) begin
      cell_b = cell_b - 8'd1;
    end
    base = row - ROW_BASE;
    if (cell_b >= CELL_SPLIT) begin
      row    = {base[6:0], 1'b0};
      cell_b = cell_b - CELL_HI_BASE;
    end else begin
      row    = {base[6:0], 1'b0} - 8'd1;
      cell_b = cell_b - CELL_LO_BASE;
    end
    return {row, cell_b};
  endfunction

endpackage

`default_nettype wire

@@ src/sjis_if.sv @@
// Valid/ready channel interfaces for the encoder's input and result items.
// Depends on nothing; payload widths are fixed byte and flag fields.
`timescale 1ns / 1ps
`default_nettype none

interface sjis_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface sjis_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ src/sjis_decode.sv @@
// Decode stage: holds the character set and pending lead byte, and turns one
// accepted input item into a run of up to five output bytes. Uses sjis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sjis_decode (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire sjis_pkg::byte_t in_byte,
  input  wire logic           end_of_text,
  output sjis_pkg::run_t      run
);
  import sjis_pkg::*;

  cset_t char_set_r;
  cset_t char_set_nxt;
  byte_t held_lead_r;
  byte_t held_lead_nxt;
  logic  lead_waiting_r;
  logic  lead_waiting_nxt;

  logic  esc;
  byte_t esc_b1;
  byte_t esc_b2;
  byte_t pay0;
  byte_t pay1;
  logic [1:0] pcnt;

  // Classify the byte against the current state and choose the escape and payload.
  always_comb begin
    cset_t cs;
    cs               = lead_waiting_r ? CS_ASCII : char_set_r;
    esc              = 1'b0;
    esc_b1           = ESC_PAREN;
    esc_b2           = FINAL_B;
    pay0             = '0;
    pay1             = '0;
    pcnt             = 2'd0;
    char_set_nxt     = char_set_r;
    held_lead_nxt    = held_lead_r;
    lead_waiting_nxt = lead_waiting_r;
    if (accept) begin
      lead_waiting_nxt = 1'b0;
      if (lead_waiting_r && is_trail(in_byte)) begin
        // Second byte of a kanji pair.
        esc          = (char_set_r != CS_KANJI);
        esc_b1       = ESC_DOLLAR;
        esc_b2       = FINAL_B;
        {pay0, pay1} = kanji_row_cell(held_lead_r, in_byte);
        pcnt         = 2'd2;
        char_set_nxt = CS_KANJI;
      end else begin
        // A first byte, or a bad trail handled afresh with the set back at ASCII.
        char_set_nxt = cs;
        if (is_ascii(in_byte)) begin
          esc          = (cs == CS_KANA) || (cs == CS_KANJI);
          esc_b2       = FINAL_B;
          pay0         = in_byte;
          pcnt         = 2'd1;
          char_set_nxt = CS_ASCII;
        end else if (is_kana(in_byte)) begin
          esc          = (cs != CS_KANA);
          esc_b2       = FINAL_I;
          pay0         = in_byte;
          pcnt         = 2'd1;
          char_set_nxt = CS_KANA;
        end else if (is_lead(in_byte) && !end_of_text) begin
          held_lead_nxt    = in_byte;
          lead_waiting_nxt = 1'b1;
        end else begin
          char_set_nxt = CS_ASCII;
        end
      end
    end
  end

  // Pack the escape, if any, ahead of the payload.
  always_comb begin
    run.bytes = '0;
    if (esc) begin
      run.bytes[0] = ESC_CODE;
      run.bytes[1] = esc_b1;
      run.bytes[2] = esc_b2;
      run.bytes[3] = pay0;
      run.bytes[4] = pay1;
      run.cnt      = CNT_W'(3) + CNT_W'(pcnt);
    end else begin
      run.bytes[0] = pay0;
      run.bytes[1] = pay1;
      run.cnt      = CNT_W'(pcnt);
    end
  end

  // Conversion state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_set_r     <= CS_ASCII;
      held_lead_r    <= '0;
      lead_waiting_r <= 1'b0;
    end else begin
      char_set_r     <= char_set_nxt;
      held_lead_r    <= held_lead_nxt;
      lead_waiting_r <= lead_waiting_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/sjis_serial.sv @@
// Output stage: registers one run of bytes and hands them out one item per
// cycle while the result channel is ready. Uses sjis_pkg and sjis_out_if.
`timescale 1ns / 1ps
`default_nettype none

module sjis_serial (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire sjis_pkg::run_t run,
  output logic               can_load,
  sjis_out_if.source         out_ch
);
  import sjis_pkg::*;

  logic [RUN_MAX-1:0][7:0] bytes_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        cnt_nxt;
  logic [IDX_W-1:0]        idx_r;
  logic [IDX_W-1:0]        idx_nxt;
  logic                    is_last;
  logic                    pop;

  assign is_last  = (CNT_W'(idx_r) == (cnt_r - CNT_W'(1)));
  assign pop      = out_ch.valid && out_ch.ready;
  // A new run may be taken once the buffer is empty or its last byte leaves now.
  assign can_load = (cnt_r == '0) || (pop && is_last);

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.out_byte    = bytes_r[idx_r];
  assign out_ch.last_of_run = is_last;

  // Run length and read position.
  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = run.cnt;
      idx_nxt = '0;
    end else if (pop) begin
      if (is_last) begin
        cnt_nxt = '0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  // Run bytes need no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= run.bytes;
    end
  end

endmodule

`default_nettype wire

@@ src/sjis_to_iso2022jp_encoder.sv @@
// Top level of the Shift_JIS to ISO-2022-JP encoder: decode stage and
// output stage. Uses sjis_pkg, sjis_if, sjis_decode and sjis_serial.
//
// Each input item is decoded in the cycle it is accepted and its output
// bytes (none to five: an optional escape of three bytes, then one
// character byte or a kanji row and cell pair) are registered as one run.
// The run leaves on the result channel one item per cycle while the receiver
// is ready, the final one flagged with last_of_run. A new input item is
// accepted when the run register is empty or in the same cycle its last byte
// is taken, so an item holds the block until all its output bytes have gone;
// items with no output (a kanji lead, a dropped byte) go through at one per
// cycle. The single output byte port sets this limit.
// A kanji lead byte is held until its trail arrives; no closing escape is
// sent at end of text and the character set carries over to the next text.
`timescale 1ns / 1ps
`default_nettype none

module sjis_to_iso2022jp_encoder (
  input  wire logic clk,
  input  wire logic rst_n,
  sjis_in_if.sink   in_ch,
  sjis_out_if.source out_ch
);
  import sjis_pkg::*;

  run_t run;
  logic can_load;
  logic accept;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  // Decode of the accepted item and conversion state.
  sjis_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_byte     (in_ch.in_byte),
    .end_of_text (in_ch.end_of_text),
    .run         (run)
  );

  // Run register and byte-wise output.
  sjis_serial u_serial (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .run      (run),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

@@ src/sjis_chk.sv @@
// Port-level checks for the encoder and the bind that attaches them to the
// top level. Depends on sjis_to_iso2022jp_encoder only through its ports.
`timescale 1ns / 1ps
`default_nettype none

module sjis_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       last_of_run
);

  // A result item that is not taken stays offered with the same byte.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("result item dropped or changed while stalled");

  // The input side only stalls while results are waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // A run does not end until its flagged last byte has gone.
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("run ended without a last byte");

  // No new item enters while the current run still has bytes to send.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_of_run |-> !in_ready)
    else $error("item accepted in the middle of a run");

endmodule

bind sjis_to_iso2022jp_encoder sjis_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .last_of_run (out_ch.last_of_run)
);

`default_nettype wire

@@ dv/sjis_to_iso2022jp_encoder_tb.sv @@
// Self-checking testbench for the Shift_JIS to ISO-2022-JP encoder.
// Depends on sjis_pkg, the sjis_in_if and sjis_out_if interfaces and the encoder top level.
`timescale 1ns / 1ps

module sjis_to_iso2022jp_encoder_tb;
  import sjis_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // One Shift_JIS source item and one expected output item.
  typedef struct {
    byte_t value;
    logic  eot;
  } sjis_src_t;

  typedef struct {
    byte_t data;
    logic  last_of_run;
  } jis_out_t;

  // Tracks the character set and any held lead byte, predicts the output
  // bytes of every accepted source byte and checks them in order.
  class jis_byte_checker;
    cset_t    cur_set;
    byte_t    held_byte;
    bit       held_valid;
    byte_t    run_bytes[$];
    jis_out_t pending_bytes[$];
    int       mismatches;

    function new();
      cur_set    = CS_ASCII;
      held_byte  = '0;
      held_valid = 1'b0;
      mismatches = 0;
    endfunction

    task flag_mismatch(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void push_escape(byte_t second, byte_t final_code);
      run_bytes.push_back(ESC_CODE);
      run_bytes.push_back(second);
      run_bytes.push_back(final_code);
    endfunction

    // A byte seen with no lead byte held.
    function void first_byte(byte_t b, logic eot);
      if (b <= 8'h7F) begin
        if (cur_set == CS_KANA || cur_set == CS_KANJI) begin
          push_escape(ESC_PAREN, FINAL_B);
        end
        run_bytes.push_back(b);
        cur_set = CS_ASCII;
      end else if (b >= 8'hA1 && b <= 8'hDF) begin
        if (cur_set != CS_KANA) begin
          push_escape(ESC_PAREN, FINAL_I);
        end
        run_bytes.push_back(b);
        cur_set = CS_KANA;
      end else if (!eot && ((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC))) begin
        held_byte  = b;
        held_valid = 1'b1;
      end else begin
        // Bad lead byte, or a lead byte at end of text: dropped.
        cur_set = CS_ASCII;
      end
    endfunction

    function void take_sjis_byte(byte_t b, logic eot);
      byte_t row;
      byte_t cell_b;
      run_bytes.delete();
      if (held_valid) begin
        held_valid = 1'b0;
        if ((b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC)) begin
          if (cur_set != CS_KANJI) begin
            push_escape(ESC_DOLLAR, FINAL_B);
          end
          // Row and cell wrap at eight bits.
          row    = held_byte;
          cell_b = b;
          if (row >= 8'hE0) begin
            row = row - ROW_HIGH_ADJ;
          end
          if (cell_b >= 8'h80) begin
            cell_b = cell_b - 8'd1;
          end
          if (cell_b >= CELL_SPLIT) begin
            row    = (row - ROW_BASE) << 1;
            cell_b = cell_b - CELL_HI_BASE;
          end else begin
            row    = ((row - ROW_BASE) << 1) - 8'd1;
            cell_b = cell_b - CELL_LO_BASE;
          end
          run_bytes.push_back(row);
          run_bytes.push_back(cell_b);
          cur_set = CS_KANJI;
        end else begin
          // Bad trail: the lead is dropped and the byte is taken afresh.
          cur_set = CS_ASCII;
          first_byte(b, eot);
        end
      end else begin
        first_byte(b, eot);
      end
      if (eot) begin
        held_valid = 1'b0;
      end
      foreach (run_bytes[i]) begin
        pending_bytes.push_back('{data: run_bytes[i],
                                   last_of_run: (i == run_bytes.size() - 1)});
      end
    endfunction

    task match_jis_byte(input byte_t data, input logic last_of_run);
      jis_out_t want;
      if (pending_bytes.size() == 0) begin
        flag_mismatch($sformatf("byte %02h arrived with nothing expected", data));
        return;
      end
      want = pending_bytes.pop_front();
      if (data !== want.data) begin
        flag_mismatch($sformatf("out_byte %02h, expected %02h", data, want.data));
      end
      if (last_of_run !== want.last_of_run) begin
        flag_mismatch($sformatf("last_of_run %b on byte %02h, expected %b",
                                last_of_run, data, want.last_of_run));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  sjis_in_if  in_bus ();
  sjis_out_if out_bus ();

  jis_byte_checker sb = new();
  sjis_src_t       src_bytes[$];
  int              burst_left = 0;
  int unsigned     cycle_count = 0;
  logic [8:0]      stall_phase = '0;

  sjis_to_iso2022jp_encoder dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both handshakes are sampled at the rising edge; input first, so that a
  // result can never overtake the byte that caused it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        sb.take_sjis_byte(in_bus.in_byte, in_bus.end_of_text);
      end
      if (out_bus.valid && out_bus.ready) begin
        sb.match_jis_byte(out_bus.out_byte, out_bus.last_of_run);
      end
    end
  end

  // The receiver runs through four stall modes in turn, set by stall_phase[8:7]:
  // always ready, coin toss, a fixed two-in-five pattern, and mostly stalled.
  always @(negedge clk) begin
    stall_phase <= stall_phase + 9'd1;
    case (stall_phase[8:7])
      2'd0: begin
        out_bus.ready <= 1'b1;
      end
      2'd1: begin
        out_bus.ready <= 1'($urandom_range(0, 1));
      end
      2'd2: begin
        out_bus.ready <= (stall_phase % 5) < 2;
      end
      default: begin
        out_bus.ready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void add_byte(byte_t value, logic eot);
    src_bytes.push_back('{value: value, eot: eot});
  endfunction

  function automatic byte_t random_lead();
    if ($urandom_range(0, 1)) begin
      return byte_t'($urandom_range(8'h81, 8'h9F));
    end
    return byte_t'($urandom_range(8'hE0, 8'hFC));
  endfunction

  // Mostly well-formed text with random content; the rest is broken pairs
  // and arbitrary bytes. End of text falls now and then.
  function automatic void add_random_text(int count);
    int    pick;
    logic  eot;
    byte_t trail;
    while (src_bytes.size() < count) begin
      pick = $urandom_range(0, 99);
      eot  = ($urandom_range(0, 19) == 0);
      if (pick < 30) begin
        add_byte(byte_t'($urandom_range(8'h00, 8'h7F)), eot);
      end else if (pick < 50) begin
        add_byte(byte_t'($urandom_range(8'hA1, 8'hDF)), eot);
      end else if (pick < 80) begin
        if ($urandom_range(0, 1)) begin
          trail = byte_t'($urandom_range(8'h40, 8'h7E));
        end else begin
          trail = byte_t'($urandom_range(8'h80, 8'hFC));
        end
        add_byte(random_lead(), ($urandom_range(0, 9) == 0));
        add_byte(trail, eot);
      end else if (pick < 90) begin
        case ($urandom_range(0, 2))
          0: trail = byte_t'($urandom_range(8'h00, 8'h3F));
          1: trail = 8'h7F;
          default: trail = byte_t'($urandom_range(8'hFD, 8'hFF));
        endcase
        add_byte(random_lead(), 1'b0);
        add_byte(trail, eot);
      end else begin
        add_byte(byte_t'($urandom_range(0, 255)), eot);
      end
    end
  endfunction

  // Sends every queued item in bursts of random length with random gaps.
  task automatic send_queued_bytes();
    sjis_src_t item;
    int        gap;
    while (src_bytes.size() > 0) begin
      item = src_bytes.pop_front();
      @(negedge clk);
      in_bus.valid       <= 1'b1;
      in_bus.in_byte     <= item.value;
      in_bus.end_of_text <= item.eot;
      @(posedge clk);
      while (!in_bus.ready) begin
        @(posedge clk);
      end
      if (burst_left > 0) begin
        burst_left--;
      end
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
        gap        = $urandom_range(0, 6);
        if (gap > 0) begin
          @(negedge clk);
          in_bus.valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
    @(negedge clk);
    in_bus.valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (sb.pending_bytes.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    in_bus.valid       = 1'b0;
    in_bus.in_byte     = '0;
    in_bus.end_of_text = 1'b0;
    out_bus.ready      = 1'b0;
    rst_n              = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed text: plain ASCII, kana entry, return to ASCII, kanji at the
    // edges of both lead ranges and both trail ranges.
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'hA1, 1'b0);
    add_byte(8'hDF, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'h81, 1'b0);
    add_byte(8'h40, 1'b0);
    add_byte(8'h9F, 1'b0);
    add_byte(8'hFC, 1'b0);
    // A bad lead byte inside kanji falls back to ASCII without an escape.
    add_byte(8'hFF, 1'b0);
    add_byte(8'h30, 1'b0);
    add_byte(8'hE0, 1'b0);
    add_byte(8'h7E, 1'b0);
    add_byte(8'h80, 1'b0);
    // Lead beyond the JIS range gives an out-of-range row byte.
    add_byte(8'hFC, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hA1, 1'b0);
    add_byte(8'hA0, 1'b0);
    // A bad trail drops the lead and is taken afresh as ASCII.
    add_byte(8'h88, 1'b0);
    add_byte(8'h3F, 1'b0);
    // A trail with end of text completes the pair.
    add_byte(8'hF0, 1'b0);
    add_byte(8'h9E, 1'b1);
    // A lead with end of text is dropped.
    add_byte(8'h95, 1'b1);
    // A bad trail that is itself a bad lead leaves nothing at all.
    add_byte(8'h88, 1'b0);
    add_byte(8'hFD, 1'b0);
    send_queued_bytes();
    wait_for_drain();

    // Random text, with a full drain of the result stream half way.
    add_random_text(200);
    send_queued_bytes();
    wait_for_drain();
    add_random_text(200);
    send_queued_bytes();
    wait_for_drain();
    repeat (12) @(negedge clk);

    if (sb.pending_bytes.size() != 0) begin
      sb.flag_mismatch($sformatf("%0d expected bytes never arrived",
                                 sb.pending_bytes.size()));
    end
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
